/* hdl/signed_decimal_ascii_formatter_assert.svh */
// Assertion macros for the signed decimal ASCII formatter.
// Depends on nothing; included by the top level.
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_ASSERT_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SDAF_ASSERT_NOW(label, clock, reset, cond, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define SDAF_ASSERT_NEXT(label, clock, reset, cond, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sdaf_pkg.sv */
// Shared constants and types for the signed decimal ASCII formatter.
// Depends on nothing.
`default_nettype none
package sdaf_pkg;
  localparam int MagWidth   = 32;
  localparam int DigitCount = 10;
  localparam int BcdWidth   = 4 * DigitCount;
  localparam int CntWidth   = $clog2(MagWidth);
  localparam int IdxWidth   = $clog2(DigitCount);
  localparam int CharWidth  = 7;
  localparam int SfxWidth   = 2;

  localparam logic [CharWidth-1:0] CH_ZERO  = 7'd48;
  localparam logic [CharWidth-1:0] CH_MINUS = 7'd45;
  localparam logic [CharWidth-1:0] CH_SPACE = 7'd32;
  localparam logic [CharWidth-1:0] CH_CR    = 7'd13;
  localparam logic [CharWidth-1:0] CH_LF    = 7'd10;

  localparam logic [SfxWidth-1:0] SFX_NONE  = 2'd0;
  localparam logic [SfxWidth-1:0] SFX_SPACE = 2'd1;
  localparam logic [SfxWidth-1:0] SFX_CRLF  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;
endpackage
`default_nettype wire

/* hdl/sdaf_if.sv */
// Valid/ready channel interfaces for the formatter's input and output items.
// Depends on sdaf_pkg.
`default_nettype none
interface sdaf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sdaf_pkg::MagWidth-1:0] value;
  logic        [sdaf_pkg::SfxWidth-1:0] suffix;
  modport source (output valid, output value, output suffix, input ready);
  modport sink (input valid, input value, input suffix, output ready);
endinterface

interface sdaf_out_if;
  logic                           valid;
  logic                           ready;
  logic [sdaf_pkg::CharWidth-1:0] character;
  logic                           last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

/* hdl/sdaf_dabble.sv */
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// Depends on sdaf_pkg.
`default_nettype none
module sdaf_dabble (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [sdaf_pkg::MagWidth-1:0]     mag,
  output logic      [sdaf_pkg::BcdWidth-1:0]     bcd,
  output sdaf_pkg::conv_stat_t                   stat
);
  logic [sdaf_pkg::MagWidth-1:0] bin;
  logic [sdaf_pkg::BcdWidth-1:0] adj;
  logic [sdaf_pkg::CntWidth-1:0] cnt;
  logic                          busy;
  logic                          done;

  always_comb begin
    for (int i = 0; i < sdaf_pkg::DigitCount; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= sdaf_pkg::CntWidth'(sdaf_pkg::MagWidth - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[sdaf_pkg::BcdWidth-2:0], bin[sdaf_pkg::MagWidth-1]};
      bin <= {bin[sdaf_pkg::MagWidth-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

/* hdl/signed_decimal_ascii_formatter.sv */
// Signed decimal ASCII formatter: an item of a signed 32-bit value and a suffix code
// becomes up to 13 characters ('-', digits without leading zeros, then nothing, a
// space, or CR LF), the final one flagged last. One item is handled at a time.
// After the item is taken, the bit-serial BCD converter runs. The sign is sent next for a
// negative value. Then the ten digit positions are walked, each leading zero skipped and
// each digit sent, and the suffix follows. A character that waits on the output holds
// back the sending of the next one until it is taken.
// The next item is taken while the final character still waits in the output register.
// Depends on sdaf_pkg, sdaf_if, sdaf_dabble and the assertion header.
`default_nettype none
`include "signed_decimal_ascii_formatter_assert.svh"
module signed_decimal_ascii_formatter (
  input wire logic clk,
  input wire logic rst,
  sdaf_in_if.sink   operand,
  sdaf_out_if.source text
);
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_DIGIT,
    S_SPACE,
    S_CR,
    S_LF
  } state_t;

  state_t                         state;
  logic                           negative;
  logic [sdaf_pkg::SfxWidth-1:0]  sfx;
  logic [sdaf_pkg::IdxWidth-1:0]  idx;
  logic                           started;
  logic                           o_valid;
  logic [sdaf_pkg::CharWidth-1:0] o_char;
  logic                           o_last;

  logic                           accept;
  logic                           emit_ok;
  logic                           load;
  logic [sdaf_pkg::MagWidth-1:0]  mag;
  logic [sdaf_pkg::BcdWidth-1:0]  bcd;
  logic [3:0]                     cur;
  sdaf_pkg::conv_stat_t           conv_stat;

  assign operand.ready  = (state == S_IDLE);
  assign accept         = operand.valid && operand.ready;
  assign emit_ok        = !o_valid || text.ready;
  assign mag            = operand.value[sdaf_pkg::MagWidth-1] ?
                          (~operand.value + 1'b1) : operand.value;
  assign cur            = bcd[4*idx +: 4];
  assign text.valid     = o_valid;
  assign text.character = o_char;
  assign text.last      = o_last;

  sdaf_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .bcd   (bcd),
    .stat  (conv_stat)
  );

  always_comb begin
    case (state)
      S_SIGN, S_SPACE, S_CR, S_LF: load = emit_ok;
      S_DIGIT: load = emit_ok && !(cur == 4'd0 && !started && idx != '0);
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      o_valid  <= 1'b0;
      started  <= 1'b0;
      idx      <= '0;
      negative <= 1'b0;
      sfx      <= sdaf_pkg::SFX_NONE;
      o_char   <= '0;
      o_last   <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
      end else if (text.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            negative <= operand.value[sdaf_pkg::MagWidth-1];
            sfx      <= operand.suffix;
            state    <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_stat.done) begin
            idx     <= sdaf_pkg::IdxWidth'(sdaf_pkg::DigitCount - 1);
            started <= 1'b0;
            state   <= negative ? S_SIGN : S_DIGIT;
          end
        end
        S_SIGN: begin
          if (emit_ok) begin
            o_char  <= sdaf_pkg::CH_MINUS;
            o_last  <= 1'b0;
            state   <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (cur == 4'd0 && !started && idx != '0) begin
            idx <= idx - 1'b1;
          end else if (emit_ok) begin
            o_char  <= sdaf_pkg::CH_ZERO + sdaf_pkg::CharWidth'(cur);
            o_last  <= (idx == '0) && (sfx != sdaf_pkg::SFX_SPACE)
                       && (sfx != sdaf_pkg::SFX_CRLF);
            started <= 1'b1;
            if (idx == '0) begin
              if (sfx == sdaf_pkg::SFX_SPACE) begin
                state <= S_SPACE;
              end else if (sfx == sdaf_pkg::SFX_CRLF) begin
                state <= S_CR;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        S_SPACE: begin
          if (emit_ok) begin
            o_char  <= sdaf_pkg::CH_SPACE;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_CR: begin
          if (emit_ok) begin
            o_char  <= sdaf_pkg::CH_CR;
            o_last  <= 1'b0;
            state   <= S_LF;
          end
        end
        S_LF: begin
          if (emit_ok) begin
            o_char  <= sdaf_pkg::CH_LF;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SDAF_ASSERT_NOW(a_accept_conv_idle, clk, rst, accept, !conv_stat.busy, "item taken while converting")
  `SDAF_ASSERT_NOW(a_done_in_conv, clk, rst, conv_stat.done, state == S_CONV, "conversion ended outside wait")
  `SDAF_ASSERT_NEXT(a_done_leaves_conv, clk, rst, conv_stat.done, state != S_CONV, "stuck after conversion")
  `SDAF_ASSERT_NOW(a_idle_not_busy, clk, rst, state == S_IDLE, !conv_stat.busy, "converter busy while idle")
endmodule
`default_nettype wire
